/* design/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Shared sizes, codes and types of the peer statistics table.
// ----------------------------------------------------------------------------
`default_nettype none

package pst_pkg;

    // Number of peer entries the table holds
    localparam int PEER_SLOTS = 8;

    // Entry index and fill count widths
    localparam int IDX_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int FILL_W = $clog2(PEER_SLOTS + 1);

    // Request types
    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_GET    = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_FULL     = 3'd2,
        ST_ZERO_ID  = 3'd3,
        ST_READ_OK  = 3'd4,
        ST_BAD_IDX  = 3'd5
    } t_status;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [31:0]        node;
        logic [31:0]        hits;
        logic [31:0]        seq;
        logic signed [7:0]  snr;
        logic signed [15:0] rssi;
        logic [31:0]        rx_time;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

/* design/peer_stats_table_top.sv */
// ----------------------------------------------------------------------------
// peer_stats_table_top
// Insert-or-update table of radio peers keyed by nonzero node id.
// ----------------------------------------------------------------------------
// A record beat searches the filled entries in index order, one entry per
// clock through the single read port of the entry RAM and one 32-bit id
// comparator; a hit rewrites that entry with its hit count bumped, a miss
// appends a new entry while there is room. A get beat reads one entry by
// index. Every beat gives exactly one result beat carrying the fill count,
// change count and hit total after that request. A zero id or bad index
// goes straight to the result, a get reads the RAM before its result, a
// record into an empty table writes without a scan, and a record against
// filled entries scans them before it writes or drops. The input is not
// ready while a request is in work; it is ready again while the previous
// result still waits.
`default_nettype none

module peer_stats_table_top
    import pst_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // request channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_req_type,
    input  wire logic [31:0]        i_node_id,
    input  wire logic [31:0]        i_pkt_seq,
    input  wire logic signed [7:0]  i_snr_quarter_db,
    input  wire logic signed [15:0] i_rssi_dbm,
    input  wire logic [31:0]        i_rx_time,
    input  wire logic [2:0]         i_read_index,

    // result channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [2:0]              o_status,
    output logic [31:0]             o_entry_node,
    output logic [31:0]             o_entry_hits,
    output logic [31:0]             o_entry_seq,
    output logic signed [7:0]       o_entry_snr,
    output logic signed [15:0]      o_entry_rssi,
    output logic [31:0]             o_entry_time,
    output logic [3:0]              o_fill_count,
    output logic [31:0]             o_change_count,
    output logic [31:0]             o_hit_total
);

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_READ  = 7'b0010000,
        S_GET   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state              r_state, n_state;

    // latched request
    logic [31:0]         r_node;
    logic [31:0]         r_seq;
    logic signed [7:0]   r_snr;
    logic signed [15:0]  r_rssi;
    logic [31:0]         r_time;

    // scan and write control
    logic [IDX_W-1:0]    r_addr, n_addr;
    logic [IDX_W-1:0]    r_waddr, n_waddr;
    logic [31:0]         r_whits, n_whits;
    t_status             r_status, n_status;
    t_entry              r_ent, n_ent;

    // table counters
    logic [FILL_W-1:0]   r_filled, n_filled;
    logic [31:0]         r_changes, n_changes;
    logic [31:0]         r_total, n_total;

    // result register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status;
    t_entry              r_out_ent;
    logic [3:0]          r_out_fill;
    logic [31:0]         r_out_changes;
    logic [31:0]         r_out_total;

    // RAM port signals
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    t_entry              ram_wdata;
    t_entry              ram_rdata;
    logic [ENTRY_W-1:0]  ram_rdata_bits;

    logic                accept;
    logic                out_free;
    logic                idx_ok;
    logic                id_match;
    logic [FILL_W-1:0]   next_pos;

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);

    // read index below fill count (and below table size, implied by fill)
    assign idx_ok   = ({29'd0, i_read_index} < 32'(r_filled));

    // shared id comparator and scan position
    assign id_match = (ram_rdata.node == r_node);
    assign next_pos = FILL_W'(r_addr) + FILL_W'(1);
    assign ram_rdata = t_entry'(ram_rdata_bits);

    // Entry RAM
    pst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PEER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_bits)
    );

    // Write data from the latched record
    always_comb begin
        ram_wdata.node    = r_node;
        ram_wdata.hits    = r_whits;
        ram_wdata.seq     = r_seq;
        ram_wdata.snr     = r_snr;
        ram_wdata.rssi    = r_rssi;
        ram_wdata.rx_time = r_time;
    end

    // Read address: the scan runs one address ahead of the compare
    always_comb begin
        ram_raddr = r_addr;
        if (r_state == S_CMP) begin
            ram_raddr = IDX_W'(next_pos);
        end
    end

    // Sequencer and datapath next values
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_waddr     = r_waddr;
        n_whits     = r_whits;
        n_status    = r_status;
        n_ent       = r_ent;
        n_filled    = r_filled;
        n_changes   = r_changes;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ent = '0;
                    if (i_req_type == REQ_GET) begin
                        if (idx_ok) begin
                            n_addr  = IDX_W'({29'd0, i_read_index});
                            n_state = S_READ;
                        end else begin
                            n_status = ST_BAD_IDX;
                            n_state  = S_DONE;
                        end
                    end else if (i_node_id == 32'd0) begin
                        n_status = ST_ZERO_ID;
                        n_state  = S_DONE;
                    end else if (r_filled == '0) begin
                        n_waddr  = '0;
                        n_whits  = 32'd1;
                        n_status = ST_APPENDED;
                        n_state  = S_WRITE;
                    end else begin
                        n_addr  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // first read issued; data arrives in S_CMP
                n_state = S_CMP;
            end
            S_CMP: begin
                if (id_match) begin
                    n_waddr  = r_addr;
                    n_whits  = ram_rdata.hits + 32'd1;
                    n_status = ST_UPDATED;
                    n_state  = S_WRITE;
                end else if (next_pos < r_filled) begin
                    n_addr = IDX_W'(next_pos);
                end else if (32'(r_filled) < 32'(PEER_SLOTS)) begin
                    n_waddr  = IDX_W'(r_filled);
                    n_whits  = 32'd1;
                    n_status = ST_APPENDED;
                    n_state  = S_WRITE;
                end else begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                n_changes = r_changes + 32'd1;
                n_total   = r_total + 32'd1;
                if (r_status == ST_APPENDED) begin
                    n_filled = r_filled + FILL_W'(1);
                end
                n_state = S_DONE;
            end
            S_READ: begin
                n_state = S_GET;
            end
            S_GET: begin
                n_ent    = ram_rdata;
                n_status = ST_READ_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_changes   <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_changes   <= n_changes;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_waddr  <= n_waddr;
        r_whits  <= n_whits;
        r_status <= n_status;
        r_ent    <= n_ent;
        if (accept) begin
            r_node <= i_node_id;
            r_seq  <= i_pkt_seq;
            r_snr  <= i_snr_quarter_db;
            r_rssi <= i_rssi_dbm;
            r_time <= i_rx_time;
        end
        // result beat snapshot
        if (r_state == S_DONE && out_free) begin
            r_out_status  <= r_status;
            r_out_ent     <= r_ent;
            r_out_fill    <= 4'(r_filled);
            r_out_changes <= r_changes;
            r_out_total   <= r_total;
        end
    end

    // Result ports
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_entry_node   = r_out_ent.node;
    assign o_entry_hits   = r_out_ent.hits;
    assign o_entry_seq    = r_out_ent.seq;
    assign o_entry_snr    = r_out_ent.snr;
    assign o_entry_rssi   = r_out_ent.rssi;
    assign o_entry_time   = r_out_ent.rx_time;
    assign o_fill_count   = r_out_fill;
    assign o_change_count = r_out_changes;
    assign o_hit_total    = r_out_total;

endmodule

`default_nettype wire

/* design/pst_ram.sv */
// ----------------------------------------------------------------------------
// pst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the peer statistics table.
// ----------------------------------------------------------------------------
// Drives record and get beats into peer_stats_table_top and checks every
// result beat against a behavioral model of the table kept in a scoreboard.
// A directed opening covers the empty table, zero ids, payload extremes,
// updates, appends up to a full table, drops on a full table and both good
// and bad read indexes. A long random phase follows over a small pool of
// known peers, unknown peers, near-miss ids, zero ids and reads. The
// sender works in bursts with random gaps, and the receiver stalls in
// changing patterns.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pst_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int POOL_SIZE    = PEER_SLOTS + 4;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 32;
    localparam int RUN_LIMIT_NS = 1_500_000;

    // One request beat as driven on the input ports
    typedef struct packed {
        logic               req_type;
        logic [31:0]        node_id;
        logic [31:0]        pkt_seq;
        logic signed [7:0]  snr;
        logic signed [15:0] rssi;
        logic [31:0]        rx_time;
        logic [2:0]         read_index;
    } t_peer_req;

    // One result beat as seen on the output ports
    typedef struct packed {
        t_status     status;
        t_entry      entry;
        logic [3:0]  fill_count;
        logic [31:0] change_count;
        logic [31:0] hit_total;
    } t_peer_result;

    // Receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the table contents and the results still awaited
    // ------------------------------------------------------------------------
    class peer_table_scoreboard;
        t_entry       peer_tab [PEER_SLOTS];
        int           fill;
        logic [31:0]  change_cnt;
        logic [31:0]  hit_cnt;
        t_peer_result awaited_results [$];
        int           status_seen [8];
        int           failures;
        int           result_cnt;

        function new();
            fill       = 0;
            change_cnt = '0;
            hit_cnt    = '0;
            failures   = 0;
            result_cnt = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        // Apply an accepted request to the table and queue its result
        function void note_request(t_peer_req r);
            t_peer_result res;
            int           slot;
            int           k;
            bit           found;

            res   = '0;
            slot  = 0;
            found = 1'b0;
            if (r.req_type == REQ_RECORD) begin
                if (r.node_id == '0) begin
                    res.status = ST_ZERO_ID;
                end else begin
                    // search filled entries in index order
                    for (k = 0; k < fill; k++) begin
                        if (!found && peer_tab[k].node == r.node_id) begin
                            found = 1'b1;
                            slot  = k;
                        end
                    end
                    if (!found && fill < PEER_SLOTS) begin
                        slot                = fill;
                        peer_tab[slot].node = r.node_id;
                        peer_tab[slot].hits = 32'd1;
                        fill++;
                        res.status = ST_APPENDED;
                    end else if (found) begin
                        peer_tab[slot].hits = peer_tab[slot].hits + 32'd1;
                        res.status = ST_UPDATED;
                    end else begin
                        res.status = ST_FULL;
                    end
                    if (res.status != ST_FULL) begin
                        peer_tab[slot].seq     = r.pkt_seq;
                        peer_tab[slot].snr     = r.snr;
                        peer_tab[slot].rssi    = r.rssi;
                        peer_tab[slot].rx_time = r.rx_time;
                        hit_cnt    = hit_cnt + 32'd1;
                        change_cnt = change_cnt + 32'd1;
                    end
                end
            end else begin
                if (int'(r.read_index) < fill) begin
                    res.entry  = peer_tab[r.read_index];
                    res.status = ST_READ_OK;
                end else begin
                    res.status = ST_BAD_IDX;
                end
            end
            res.fill_count   = fill[3:0];
            res.change_count = change_cnt;
            res.hit_total    = hit_cnt;
            status_seen[int'(res.status)]++;
            awaited_results.push_back(res);
        endfunction

        // One field compare; reports the first few mismatches only
        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch at result %0d, %s: expected %h, got %h",
                             result_cnt, name, want_v, got_v);
            end
        endfunction

        // Check one accepted result beat against the oldest expectation
        function void check_result(t_peer_result got);
            t_peer_result want;

            result_cnt++;
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result beat %0d, status %0d",
                             result_cnt, got.status);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status",       32'(want.status),     32'(got.status));
            compare_field("entry_node",   want.entry.node,      got.entry.node);
            compare_field("entry_hits",   want.entry.hits,      got.entry.hits);
            compare_field("entry_seq",    want.entry.seq,       got.entry.seq);
            compare_field("entry_snr",    32'(want.entry.snr),  32'(got.entry.snr));
            compare_field("entry_rssi",   32'(want.entry.rssi), 32'(got.entry.rssi));
            compare_field("entry_time",   want.entry.rx_time,   got.entry.rx_time);
            compare_field("fill_count",   32'(want.fill_count), 32'(got.fill_count));
            compare_field("change_count", want.change_count,    got.change_count);
            compare_field("hit_total",    want.hit_total,       got.hit_total);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_valid          = 1'b0;
    logic               o_ready;
    logic               i_req_type       = 1'b0;
    logic [31:0]        i_node_id        = '0;
    logic [31:0]        i_pkt_seq        = '0;
    logic signed [7:0]  i_snr_quarter_db = '0;
    logic signed [15:0] i_rssi_dbm       = '0;
    logic [31:0]        i_rx_time        = '0;
    logic [2:0]         i_read_index     = '0;
    logic               o_valid;
    logic               i_ready          = 1'b0;
    logic [2:0]         o_status;
    logic [31:0]        o_entry_node;
    logic [31:0]        o_entry_hits;
    logic [31:0]        o_entry_seq;
    logic signed [7:0]  o_entry_snr;
    logic signed [15:0] o_entry_rssi;
    logic [31:0]        o_entry_time;
    logic [3:0]         o_fill_count;
    logic [31:0]        o_change_count;
    logic [31:0]        o_hit_total;

    peer_table_scoreboard sb;
    logic [31:0]          peer_ids [POOL_SIZE];
    t_peer_result         seen_result;
    t_rx_mode             rx_mode  = RX_OPEN;
    logic [15:0]          rx_cycle = '0;
    int                   sent_cnt = 0;

    peer_stats_table_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_node_id        (i_node_id),
        .i_pkt_seq        (i_pkt_seq),
        .i_snr_quarter_db (i_snr_quarter_db),
        .i_rssi_dbm       (i_rssi_dbm),
        .i_rx_time        (i_rx_time),
        .i_read_index     (i_read_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_entry_node     (o_entry_node),
        .o_entry_hits     (o_entry_hits),
        .o_entry_seq      (o_entry_seq),
        .o_entry_snr      (o_entry_snr),
        .o_entry_rssi     (o_entry_rssi),
        .o_entry_time     (o_entry_time),
        .o_fill_count     (o_fill_count),
        .o_change_count   (o_change_count),
        .o_hit_total      (o_hit_total)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------------
    function automatic t_peer_req mk_record(logic [31:0] id, logic [31:0] seq,
                                            logic signed [7:0] snr,
                                            logic signed [15:0] rssi,
                                            logic [31:0] rtime);
        t_peer_req r;
        r.req_type   = REQ_RECORD;
        r.node_id    = id;
        r.pkt_seq    = seq;
        r.snr        = snr;
        r.rssi       = rssi;
        r.rx_time    = rtime;
        r.read_index = 3'($urandom());
        return r;
    endfunction

    function automatic t_peer_req mk_get(logic [2:0] idx);
        t_peer_req r;
        r            = mk_record($urandom(), $urandom(), 8'($urandom()),
                                 16'($urandom()), $urandom());
        r.req_type   = REQ_GET;
        r.read_index = idx;
        return r;
    endfunction

    // Mostly known peers so the table sees real update traffic
    function automatic t_peer_req random_request();
        t_peer_req r;
        int        pick;
        r    = mk_record($urandom(), $urandom(), 8'($urandom()), 16'($urandom()),
                         $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.node_id = peer_ids[$urandom_range(0, PEER_SLOTS - 1)];
        else if (pick < 62)
            r.node_id = peer_ids[$urandom_range(PEER_SLOTS, POOL_SIZE - 1)];
        else if (pick < 66)
            // one bit off a stored id
            r.node_id = peer_ids[$urandom_range(0, PEER_SLOTS - 1)]
                        ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 70)
            r.node_id = '0;
        else if (pick >= 73)
            r.req_type = REQ_GET;
        return r;
    endfunction

    // Present one beat and hold it until accepted
    task automatic send_request(input t_peer_req r);
        i_valid          <= 1'b1;
        i_req_type       <= r.req_type;
        i_node_id        <= r.node_id;
        i_pkt_seq        <= r.pkt_seq;
        i_snr_quarter_db <= r.snr;
        i_rssi_dbm       <= r.rssi;
        i_rx_time        <= r.rx_time;
        i_read_index     <= r.read_index;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(r);
        sent_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check accepted beats, then pick next ready value
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            seen_result.status        = t_status'(o_status);
            seen_result.entry.node    = o_entry_node;
            seen_result.entry.hits    = o_entry_hits;
            seen_result.entry.seq     = o_entry_seq;
            seen_result.entry.snr     = o_entry_snr;
            seen_result.entry.rssi    = o_entry_rssi;
            seen_result.entry.rx_time = o_entry_time;
            seen_result.fill_count    = o_fill_count;
            seen_result.change_count  = o_change_count;
            seen_result.hit_total     = o_hit_total;
            sb.check_result(seen_result);
        end
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[6:0] == '0)
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:  i_ready <= 1'b1;
            RX_LIGHT: i_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: i_ready <= ($urandom_range(0, 2) == 0);
            default:  i_ready <= (rx_cycle[3:0] < 4'd5);
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int k;
        int burst;
        int gap;
        int rand_sent;

        sb          = new();
        peer_ids[0] = 32'h0000_0001;
        peer_ids[1] = 32'hFFFF_FFFF;
        for (k = 2; k < POOL_SIZE; k++) peer_ids[k] = $urandom() | 32'h0000_0100;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, zero id, payload extremes
        send_request(mk_get(3'd0));
        send_request(mk_record('0, $urandom(), 8'($urandom()), 16'($urandom()),
                               $urandom()));
        send_request(mk_record(peer_ids[0], '0, 8'sh80, 16'sh8000, '0));
        send_request(mk_record(peer_ids[1], '1, 8'sh7F, 16'sh7FFF, '1));
        send_request(mk_get(3'd1));
        send_request(mk_get(3'd2));
        send_request(mk_record(peer_ids[0], 32'h5A5A_A5A5, 8'sd1, -16'sd1, 32'h1234_5678));
        send_request(mk_get(3'd0));

        // directed: fill the table
        for (k = 2; k < PEER_SLOTS; k++)
            send_request(mk_record(peer_ids[k], $urandom(), 8'($urandom()),
                                   16'($urandom()), $urandom()));

        // directed: full table behavior
        send_request(mk_record(peer_ids[PEER_SLOTS], $urandom(), 8'($urandom()),
                               16'($urandom()), $urandom()));
        send_request(mk_record(peer_ids[PEER_SLOTS - 1], $urandom(), 8'($urandom()),
                               16'($urandom()), $urandom()));
        send_request(mk_record('0, $urandom(), 8'($urandom()), 16'($urandom()),
                               $urandom()));
        send_request(mk_get(3'd7));
        send_request(mk_get(3'd0));

        // random bursts with gaps; some long back-to-back stretches
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
            for (k = 0; k < burst; k++) begin
                send_request(random_request());
                rand_sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // drain
        while (sb.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests, %0d results checked, %0d failures",
                 sent_cnt, sb.result_cnt, sb.failures);
        $display("Seen: %0d updates, %0d appends, %0d full drops,",
                 sb.status_seen[ST_UPDATED], sb.status_seen[ST_APPENDED],
                 sb.status_seen[ST_FULL]);
        $display("      %0d zero ids, %0d reads, %0d bad indexes",
                 sb.status_seen[ST_ZERO_ID], sb.status_seen[ST_READ_OK],
                 sb.status_seen[ST_BAD_IDX]);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #RUN_LIMIT_NS;
        $display("timeout after %0d ns", RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
design/pst_pkg.sv
design/pst_ram.sv
design/peer_stats_table_top.sv
verif/testbench.sv
